@@ rtl/core/touch_gesture_classifier_macros.svh @@
// Assertion macros shared by the touch gesture classifier RTL.
// Each macro expands to one labeled concurrent assertion clocked on clk, reset by rst_n.
`ifndef TOUCH_GESTURE_CLASSIFIER_MACROS_SVH
`define TOUCH_GESTURE_CLASSIFIER_MACROS_SVH

// Same-cycle implication.
`define TGC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TGC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/tgc_pkg.sv @@
// Shared types and codes for the touch gesture classifier.
// No dependencies; used by tgc_step and touch_gesture_classifier.
package tgc_pkg;

  typedef enum logic [1:0] {
    CMD_DOWN   = 2'd0,
    CMD_MOTION = 2'd1,
    CMD_UP     = 2'd2,
    CMD_OTHER  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_NONE   = 2'd0,
    MODE_CLICK  = 2'd1,
    MODE_SCROLL = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_CLICK  = 2'd1,
    KIND_SCROLL = 2'd2
  } kind_t;

  localparam logic PHASE_CHANGED = 1'b0;
  localparam logic PHASE_ENDED   = 1'b1;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVATE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE  = 3'd4;

  localparam logic [15:0] STEP_RST     = 16'd40;
  localparam logic [15:0] TIME_RST     = 16'd200;
  localparam logic [15:0] MOVE_RST     = 16'd8;
  localparam logic [15:0] ACTIVATE_RST = 16'd15;
  localparam logic [15:0] RELEASE_RST  = 16'd30;

  typedef struct packed {
    logic [15:0] step_thr;
    logic [15:0] time_thr;
    logic [15:0] move_thr;
    logic [15:0] activate_thr;
    logic [15:0] release_thr;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] start_x;
    logic [15:0] start_y;
    logic [31:0] start_time;
    logic [15:0] last_x;
    logic [15:0] last_y;
    logic        x_broken;
    logic        y_broken;
  } gest_state_t;

  typedef struct packed {
    kind_t              kind;
    logic               phase;
    logic [31:0]        event_time;
    logic [15:0]        event_x;
    logic [15:0]        event_y;
    logic signed [16:0] delta_x;
    logic signed [16:0] delta_y;
  } result_t;

endpackage

@@ rtl/core/tgc_step.sv @@
// Classification step: next gesture state and result for one touch event.
// Pure combinational; depends on tgc_pkg.
module tgc_step (
  input  tgc_pkg::cmd_t        cmd,
  input  logic [15:0]          pos_x,
  input  logic [15:0]          pos_y,
  input  logic [31:0]          stamp,
  input  tgc_pkg::cfg_t        cfg,
  input  tgc_pkg::gest_state_t st,
  output tgc_pkg::gest_state_t st_nxt,
  output tgc_pkg::result_t     res
);

  logic [15:0] x_off;
  logic [15:0] y_off;
  logic [31:0] elapsed;
  logic        over;
  logic        band;
  logic        x_brk;
  logic        y_brk;
  logic        scroll_go;

  assign x_off   = (pos_x >= st.start_x) ? pos_x - st.start_x : st.start_x - pos_x;
  assign y_off   = (pos_y >= st.start_y) ? pos_y - st.start_y : st.start_y - pos_y;
  assign elapsed = stamp - st.start_time;
  assign over    = (x_off >= cfg.step_thr) || (y_off >= cfg.step_thr)
                || (elapsed >= {16'd0, cfg.time_thr});

  // diagonal band: both offsets in [move, activate) breaks both locks
  assign band  = (x_off >= cfg.move_thr) && (y_off >= cfg.move_thr)
              && (x_off < cfg.activate_thr) && (y_off < cfg.activate_thr);
  assign x_brk = st.x_broken || (x_off >= cfg.release_thr) || band;
  assign y_brk = st.y_broken || (y_off >= cfg.release_thr) || band;

  assign scroll_go = (st.mode == tgc_pkg::MODE_SCROLL)
                  || ((st.mode == tgc_pkg::MODE_CLICK) && over);

  always_comb begin
    st_nxt = st;
    res    = '0;
    unique case (cmd)
      tgc_pkg::CMD_DOWN: begin
        st_nxt.mode       = tgc_pkg::MODE_CLICK;
        st_nxt.start_x    = pos_x;
        st_nxt.start_y    = pos_y;
        st_nxt.start_time = stamp;
        st_nxt.last_x     = pos_x;
        st_nxt.last_y     = pos_y;
        st_nxt.x_broken   = 1'b0;
        st_nxt.y_broken   = 1'b0;
      end
      tgc_pkg::CMD_MOTION: begin
        if (scroll_go) begin
          st_nxt.mode     = tgc_pkg::MODE_SCROLL;
          st_nxt.x_broken = x_brk;
          st_nxt.y_broken = y_brk;
          st_nxt.last_x   = pos_x;
          st_nxt.last_y   = pos_y;
          res.kind        = tgc_pkg::KIND_SCROLL;
          res.phase       = tgc_pkg::PHASE_CHANGED;
          res.event_time  = stamp;
          res.event_x     = st.start_x;
          res.event_y     = st.start_y;
          if (x_brk || (y_off < cfg.activate_thr)) begin
            res.delta_x = $signed({1'b0, pos_x}) - $signed({1'b0, st.last_x});
          end
          if (y_brk || (x_off < cfg.activate_thr)) begin
            res.delta_y = $signed({1'b0, pos_y}) - $signed({1'b0, st.last_y});
          end
        end
      end
      tgc_pkg::CMD_UP: begin
        if (st.mode == tgc_pkg::MODE_CLICK) begin
          st_nxt.mode    = tgc_pkg::MODE_NONE;
          res.kind       = tgc_pkg::KIND_CLICK;
          res.event_time = stamp;
          res.event_x    = pos_x;
          res.event_y    = pos_y;
        end else if (st.mode == tgc_pkg::MODE_SCROLL) begin
          st_nxt.mode    = tgc_pkg::MODE_NONE;
          st_nxt.last_x  = 16'd0;
          st_nxt.last_y  = 16'd0;
          res.kind       = tgc_pkg::KIND_SCROLL;
          res.phase      = tgc_pkg::PHASE_ENDED;
          res.event_time = stamp;
          res.event_x    = st.start_x;
          res.event_y    = st.start_y;
        end
      end
      tgc_pkg::CMD_OTHER: begin
        // ignored, no event
      end
    endcase
  end

endmodule

@@ rtl/core/touch_gesture_classifier.sv @@
// Touch gesture classifier top level: input register, gesture state, result register.
// Depends on tgc_pkg, tgc_step and touch_gesture_classifier_macros.svh.
//
// Takes one touch event (down, motion, up) per cycle unless out_tready stalls, and returns
// exactly one result per event: no event, click, or scroll with start point and axis-locked
// deltas. An input transfer goes to the input register, then via tgc_step to the result
// register that drives out_*. The sustained rate of one event per clock is set by the
// combinational state update in tgc_step. Backpressure on out_tready stalls the input side
// only when input and result registers both hold data. The user writes threshold registers
// through cfg_* while no event is in flight; the block itself does not enforce this.
`include "touch_gesture_classifier_macros.svh"

module touch_gesture_classifier (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tgc_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [15:0]                   cfg_wdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [63:0]                   in_tdata,  // pos_x[15:0], pos_y[31:16], stamp[63:32]
  input  logic [1:0]                    in_tuser,  // command[1:0]
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // event_time[31:0], event_x[47:32], event_y[63:48], delta_x[80:64], delta_y[97:81]
  output logic [103:0]                  out_tdata,
  output logic [2:0]                    out_tuser  // kind[1:0], phase[2]
);

  tgc_pkg::cfg_t        cfg_r;
  tgc_pkg::gest_state_t state_r;
  tgc_pkg::gest_state_t state_nxt;
  tgc_pkg::result_t     res_nxt;
  tgc_pkg::result_t     res_r;

  logic          s1_valid_r;
  tgc_pkg::cmd_t s1_cmd_r;
  logic [15:0]   s1_x_r;
  logic [15:0]   s1_y_r;
  logic [31:0]   s1_t_r;
  logic          out_valid_r;

  logic out_adv;
  logic s1_move;
  logic in_xfer;

  assign out_adv   = !out_valid_r || out_tready;
  assign s1_move   = s1_valid_r && out_adv;
  assign in_tready = !s1_valid_r || out_adv;
  assign in_xfer   = in_tvalid && in_tready;

  tgc_step u_step (
    .cmd    (s1_cmd_r),
    .pos_x  (s1_x_r),
    .pos_y  (s1_y_r),
    .stamp  (s1_t_r),
    .cfg    (cfg_r),
    .st     (state_r),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  // control, gesture state and thresholds
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r           <= 1'b0;
      out_valid_r          <= 1'b0;
      state_r              <= '0;
      cfg_r.step_thr       <= tgc_pkg::STEP_RST;
      cfg_r.time_thr       <= tgc_pkg::TIME_RST;
      cfg_r.move_thr       <= tgc_pkg::MOVE_RST;
      cfg_r.activate_thr   <= tgc_pkg::ACTIVATE_RST;
      cfg_r.release_thr    <= tgc_pkg::RELEASE_RST;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_move) begin
        state_r <= state_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_addr)
          tgc_pkg::CFG_STEP:     cfg_r.step_thr     <= cfg_wdata;
          tgc_pkg::CFG_TIME:     cfg_r.time_thr     <= cfg_wdata;
          tgc_pkg::CFG_MOVE:     cfg_r.move_thr     <= cfg_wdata;
          tgc_pkg::CFG_ACTIVATE: cfg_r.activate_thr <= cfg_wdata;
          tgc_pkg::CFG_RELEASE:  cfg_r.release_thr  <= cfg_wdata;
          default: ;  // drop writes beyond the register list
        endcase
      end
    end
  end

  // payload: hold while stalled
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_cmd_r <= tgc_pkg::cmd_t'(in_tuser);
      s1_x_r   <= in_tdata[15:0];
      s1_y_r   <= in_tdata[31:16];
      s1_t_r   <= in_tdata[63:32];
    end
    if (s1_move) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = {res_r.phase, res_r.kind};
  assign out_tdata  = {6'd0, res_r.delta_y, res_r.delta_x, res_r.event_y, res_r.event_x,
                       res_r.event_time};

  `TGC_ASSERT_NOW(a_none_is_zero,
    out_valid_r && (res_r.kind == tgc_pkg::KIND_NONE),
    (res_r.phase == tgc_pkg::PHASE_CHANGED) && (out_tdata == '0),
    "no-event result carries data")
  `TGC_ASSERT_NOW(a_click_no_delta,
    out_valid_r && (res_r.kind == tgc_pkg::KIND_CLICK),
    (res_r.phase == tgc_pkg::PHASE_CHANGED) && (res_r.delta_x == '0)
      && (res_r.delta_y == '0),
    "click result has deltas or phase")
  `TGC_ASSERT_NEXT(a_down_enters_click,
    s1_move && (s1_cmd_r == tgc_pkg::CMD_DOWN),
    (state_r.mode == tgc_pkg::MODE_CLICK) && !state_r.x_broken && !state_r.y_broken,
    "down did not restart gesture")
  `TGC_ASSERT_NEXT(a_end_clears_last,
    s1_move && (res_nxt.phase == tgc_pkg::PHASE_ENDED),
    (state_r.mode == tgc_pkg::MODE_NONE) && (state_r.last_x == '0)
      && (state_r.last_y == '0),
    "scroll end left state behind")
  `TGC_ASSERT_NEXT(a_result_follows, s1_move, out_valid_r,
    "moved item lost before result register")

endmodule
